FILE: rtl/core/otp_wb_pkg.sv
// Package with types and constants for the OTP white balance gain calculator.
package otp_wb_pkg;

    localparam int unsigned RATIO_W  = 10;
    localparam int unsigned GAIN_W   = 14;
    localparam int unsigned PM_W     = 20;
    localparam int unsigned NUM_W    = 30;
    localparam int unsigned QUOT_W   = 24;

    localparam logic [RATIO_W-1:0] TYP_RG_RESET  = 10'h142;
    localparam logic [RATIO_W-1:0] TYP_BG_RESET  = 10'h11d;
    localparam logic [10:0]        FACTOR_OFFSET = 11'd512;
    localparam logic [PM_W-1:0]    PER_MILLE     = 20'd1000;
    localparam logic [GAIN_W-1:0]  UNITY_GAIN    = 14'h400;
    localparam logic [GAIN_W-1:0]  GAIN_MAX      = 14'h3fff;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    localparam logic [1:0] REG_TYP_RG = 2'd0;
    localparam logic [1:0] REG_TYP_BG = 2'd1;
    localparam logic [1:0] REG_NONE   = 2'd3;

    typedef struct packed {
        logic [RATIO_W-1:0] mod_rg;
        logic [RATIO_W-1:0] mod_bg;
        logic [RATIO_W-1:0] src_rg;
        logic [RATIO_W-1:0] src_bg;
    } t_in_beat;

    typedef struct packed {
        logic [GAIN_W-1:0] red_gain;
        logic [GAIN_W-1:0] green_gain;
        logic [GAIN_W-1:0] blue_gain;
        logic              red_apply;
        logic              green_apply;
        logic              blue_apply;
        logic [1:0]        status;
    } t_out_beat;

    // Sideband that travels with a divider operation.
    typedef struct packed {
        logic [1:0]     status;
        logic [PM_W-1:0] aux;
    } t_side;

endpackage

FILE: rtl/core/otp_wb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module otp_wb_div
    import otp_wb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [PM_W-1:0]   i_den,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [QUOT_W-1:0] o_quot,
    output t_side             o_side
);

    logic [NUM_W-1:0]  r_rem  [QUOT_W+1];
    logic [QUOT_W-1:0] r_quot [QUOT_W+1];
    logic [PM_W-1:0]   r_den  [QUOT_W+1];
    t_side             r_side [QUOT_W+1];
    logic              r_vld  [QUOT_W+1];

    always_comb begin
        r_rem[0]  = i_num;
        r_quot[0] = '0;
        r_den[0]  = i_den;
        r_side[0] = i_side;
        r_vld[0]  = i_valid;
    end

    for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
        localparam int unsigned SH = QUOT_W - 1 - s;
        logic [NUM_W+QUOT_W-1:0] n_sub;
        logic                    n_fit;
        assign n_sub = {{(NUM_W+QUOT_W-PM_W){1'b0}}, r_den[s]} << SH;
        assign n_fit = {{QUOT_W{1'b0}}, r_rem[s]} >= n_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1]  <= n_fit ? r_rem[s] - n_sub[NUM_W-1:0] : r_rem[s];
            r_quot[s+1] <= {r_quot[s][QUOT_W-2:0], n_fit};
            r_den[s+1]  <= r_den[s];
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_vld[QUOT_W];
    assign o_quot  = r_quot[QUOT_W];
    assign o_side  = r_side[QUOT_W];

endmodule

FILE: rtl/core/otp_wb_front.sv
// Front stages: ratio scaling, record checks and per-mille numerators.
module otp_wb_front
    import otp_wb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_in_beat           i_beat,
    input  logic [RATIO_W-1:0] i_typ_rg,
    input  logic [RATIO_W-1:0] i_typ_bg,
    output logic               o_valid,
    output logic [NUM_W-1:0]   o_num_r,
    output logic [PM_W-1:0]    o_den_r,
    output logic [NUM_W-1:0]   o_num_b,
    output logic [PM_W-1:0]    o_den_b,
    output logic [1:0]         o_status
);

    logic               r_vld;
    logic [20:0]        r_prod_rg, r_prod_bg;
    logic               r_zero_rg;
    logic [RATIO_W-1:0] r_typ_rg, r_typ_bg;
    logic [RATIO_W:0]   n_rg, n_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
        r_prod_rg <= (i_beat.src_rg == '0) ? {1'b0, i_beat.mod_rg, 10'd0}
                   : 21'(i_beat.mod_rg) * 21'(11'(i_beat.src_rg) + FACTOR_OFFSET);
        r_prod_bg <= (i_beat.src_bg == '0) ? {1'b0, i_beat.mod_bg, 10'd0}
                   : 21'(i_beat.mod_bg) * 21'(11'(i_beat.src_bg) + FACTOR_OFFSET);
        r_zero_rg <= (i_beat.mod_rg == '0);
        r_typ_rg  <= i_typ_rg;
        r_typ_bg  <= i_typ_bg;
    end

    assign n_rg = r_prod_rg[20:10];
    assign n_bg = r_prod_bg[20:10];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld;
        end
        o_num_r <= NUM_W'(r_typ_rg * PER_MILLE);
        o_num_b <= NUM_W'(r_typ_bg * PER_MILLE);
        o_den_r <= PM_W'(n_rg);
        o_den_b <= PM_W'(n_bg);
        if (r_zero_rg) begin
            o_status <= ST_INVALID;
        end else if (n_rg == '0 || n_bg == '0) begin
            o_status <= ST_DIVZERO;
        end else begin
            o_status <= ST_OK;
        end
    end

endmodule

FILE: rtl/core/otp_white_balance_gain_calc.sv
// Top level of the OTP white balance gain calculator with its APB register port.
// One record is taken every cycle (busy stays low). Its gains pass the front stages, then
// two 24-stage pipelined dividers in series (per-mille ratios, then channel gains) with the
// base selection register between, then the output register; results cannot be stalled.
module otp_white_balance_gain_calc
    import otp_wb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_beat    i_beat,
    output logic        o_strobe,
    output t_out_beat   o_beat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [RATIO_W-1:0] r_typ_rg, r_typ_bg;
    logic [1:0]         n_idx;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign n_idx  = paddr[1:0] == 2'd0 ? {1'b0, paddr[2]} : REG_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_typ_rg <= TYP_RG_RESET;
            r_typ_bg <= TYP_BG_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (n_idx)
                REG_TYP_RG: r_typ_rg <= pwdata[RATIO_W-1:0];
                REG_TYP_BG: r_typ_bg <= pwdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (n_idx)
            REG_TYP_RG: prdata = {22'd0, r_typ_rg};
            REG_TYP_BG: prdata = {22'd0, r_typ_bg};
            default:    prdata = '0;
        endcase
    end

    logic             f_vld;
    logic [NUM_W-1:0] f_num_r, f_num_b;
    logic [PM_W-1:0]  f_den_r, f_den_b;
    logic [1:0]       f_st;

    otp_wb_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (start && !busy),
        .i_beat,
        .i_typ_rg (r_typ_rg),
        .i_typ_bg (r_typ_bg),
        .o_valid (f_vld),
        .o_num_r (f_num_r),
        .o_den_r (f_den_r),
        .o_num_b (f_num_b),
        .o_den_b (f_den_b),
        .o_status(f_st)
    );

    // Zero divisors only occur with a failed status; force them to one.
    logic [PM_W-1:0]   d_den_r, d_den_b;
    logic              p_vld, p_vld_b;
    logic [QUOT_W-1:0] p_r, p_b;
    t_side             p_side, p_side_b;
    assign d_den_r = (f_den_r == '0) ? PM_W'(1) : f_den_r;
    assign d_den_b = (f_den_b == '0) ? PM_W'(1) : f_den_b;

    otp_wb_div u_div_pmr (
        .i_clk, .i_rst_n, .i_valid(f_vld), .i_num(f_num_r), .i_den(d_den_r),
        .i_side('{status: f_st, aux: '0}),
        .o_valid(p_vld), .o_quot(p_r), .o_side(p_side)
    );
    otp_wb_div u_div_pmb (
        .i_clk, .i_rst_n, .i_valid(f_vld), .i_num(f_num_b), .i_den(d_den_b),
        .i_side('{status: f_st, aux: '0}),
        .o_valid(p_vld_b), .o_quot(p_b), .o_side(p_side_b)
    );

    // Base selection stage.
    logic              r_b_vld;
    logic [PM_W-1:0]   r_pm_r, r_pm_b, r_base;
    logic [1:0]        r_b_st;
    logic [PM_W-1:0]   n_pm_r, n_pm_b, n_base;
    assign n_pm_r = p_r[PM_W-1:0];
    assign n_pm_b = p_b[PM_W-1:0];
    always_comb begin
        if (n_pm_r < PER_MILLE || n_pm_b < PER_MILLE) begin
            n_base = (n_pm_r < n_pm_b) ? n_pm_r : n_pm_b;
        end else begin
            n_base = PER_MILLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= p_vld;
        end
        r_pm_r <= n_pm_r;
        r_pm_b <= n_pm_b;
        r_base <= (n_base == '0) ? PM_W'(1) : n_base;
        if (p_side.status != ST_OK) begin
            r_b_st <= p_side.status;
        end else if (n_base == '0) begin
            r_b_st <= ST_DIVZERO;
        end else begin
            r_b_st <= ST_OK;
        end
    end

    logic              g_vld, g_vld_g, g_vld_b;
    logic [QUOT_W-1:0] g_r, g_g, g_b;
    t_side             g_side, g_side_g, g_side_b;

    otp_wb_div u_div_gr (
        .i_clk, .i_rst_n, .i_valid(r_b_vld), .i_num(NUM_W'({r_pm_r, 10'd0})),
        .i_den(r_base), .i_side('{status: r_b_st, aux: '0}),
        .o_valid(g_vld), .o_quot(g_r), .o_side(g_side)
    );
    otp_wb_div u_div_gg (
        .i_clk, .i_rst_n, .i_valid(r_b_vld), .i_num(NUM_W'({PER_MILLE, 10'd0})),
        .i_den(r_base), .i_side('{status: r_b_st, aux: '0}),
        .o_valid(g_vld_g), .o_quot(g_g), .o_side(g_side_g)
    );
    otp_wb_div u_div_gb (
        .i_clk, .i_rst_n, .i_valid(r_b_vld), .i_num(NUM_W'({r_pm_b, 10'd0})),
        .i_den(r_base), .i_side('{status: r_b_st, aux: '0}),
        .o_valid(g_vld_b), .o_quot(g_b), .o_side(g_side_b)
    );

    function automatic logic [GAIN_W-1:0] sat(input logic [QUOT_W-1:0] q);
        sat = (q > QUOT_W'(GAIN_MAX)) ? GAIN_MAX : q[GAIN_W-1:0];
    endfunction

    logic [GAIN_W-1:0] n_gr, n_gg, n_gb;
    logic              n_ok;
    assign n_ok = (g_side.status == ST_OK);
    assign n_gr = n_ok ? sat(g_r) : '0;
    assign n_gg = n_ok ? sat(g_g) : '0;
    assign n_gb = n_ok ? sat(g_b) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= g_vld;
        end
        o_beat.red_gain    <= n_gr;
        o_beat.green_gain  <= n_gg;
        o_beat.blue_gain   <= n_gb;
        o_beat.red_apply   <= n_ok && (n_gr > UNITY_GAIN);
        o_beat.green_apply <= n_ok && (n_gg > UNITY_GAIN);
        o_beat.blue_apply  <= n_ok && (n_gb > UNITY_GAIN);
        o_beat.status      <= g_side.status;
    end

`ifndef ASSERT_OFF
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_vld == g_vld_g && g_vld == g_vld_b && p_vld == p_vld_b)
        else $error("divider lanes out of step");
    a_side_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_vld |-> g_side.status == g_side_g.status && g_side.status == g_side_b.status
            && p_side.status == p_side_b.status)
        else $error("status lanes disagree");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_beat.status != ST_OK |-> o_beat.red_gain == '0
            && o_beat.green_gain == '0 && o_beat.blue_gain == '0)
        else $error("gains not cleared on failure");
`endif

endmodule
